### rtl/core/modular_exponentiation_assert.svh
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property forms for the core's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MEXP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define MEXP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation core
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int FIELD_W    = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_ACC,
        OP_START_SQ,
        OP_STEP,
        OP_WB_RES,
        OP_WB_SQ,
        OP_WB_SQ_SHIFT,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_RED_WB,
        S_BIT,
        S_MUL_RES,
        S_RES_WB,
        S_SQ_START,
        S_MUL_SQ,
        S_SQ_WB
    } state_t;

    typedef struct packed {
        logic mul_last;
        logic exp_bit;
        logic exp_done;
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/mexp_cfg.sv
// ----------------------------------------------------------------------------
// mexp_cfg
// apb register bank holding the modulus and exponent
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_cfg
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [DATA_WIDTH-1:0] modulus,
    output logic      [DATA_WIDTH-1:0] exponent
);

    logic [DATA_WIDTH-1:0] modulus_reg;
    logic [DATA_WIDTH-1:0] exponent_reg;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= DATA_WIDTH'(1);
            exponent_reg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MODULUS:  modulus_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_EXPONENT: exponent_reg <= pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MODULUS:  prdata = CFG_DATA_W'(modulus_reg);
            REG_EXPONENT: prdata = CFG_DATA_W'(exponent_reg);
            default:      prdata = '0;
        endcase
    end

    assign modulus  = modulus_reg;
    assign exponent = exponent_reg;

endmodule

`default_nettype wire

### rtl/core/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for reduction, multiply and square passes and the output slot
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_assert.svh"

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output op_t        op
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op            = OP_NONE;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                op = OP_STEP;
                if (stat.mul_last) begin
                    state_next = S_RED_WB;
                end
            end
            S_RED_WB: begin
                op         = OP_WB_SQ;
                state_next = S_BIT;
            end
            S_BIT: begin
                if (stat.exp_done) begin
                    if (!m_tvalid_reg || m_tready) begin
                        op            = OP_FINISH;
                        m_tvalid_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else if (stat.exp_bit) begin
                    op         = OP_START_ACC;
                    state_next = S_MUL_RES;
                end else begin
                    op         = OP_START_SQ;
                    state_next = S_MUL_SQ;
                end
            end
            S_MUL_RES: begin
                op = OP_STEP;
                if (stat.mul_last) begin
                    state_next = S_RES_WB;
                end
            end
            S_RES_WB: begin
                op         = OP_WB_RES;
                state_next = S_SQ_START;
            end
            S_SQ_START: begin
                op         = OP_START_SQ;
                state_next = S_MUL_SQ;
            end
            S_MUL_SQ: begin
                op = OP_STEP;
                if (stat.mul_last) begin
                    state_next = S_SQ_WB;
                end
            end
            S_SQ_WB: begin
                op         = OP_WB_SQ_SHIFT;
                state_next = S_BIT;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    `MEXP_ASSERT_IMP(a_finish_slot_free, aclk, aresetn, op == OP_FINISH,
        !m_tvalid_reg || m_tready)
    `MEXP_ASSERT_NXT(a_finish_sets_valid, aclk, aresetn, op == OP_FINISH, m_tvalid_reg)

endmodule

`default_nettype wire

### rtl/core/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// operand registers and bit-serial interleaved modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_assert.svh"

module mexp_dp
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire op_t                   op,
    input  wire logic [DATA_WIDTH-1:0] base_value,
    input  wire logic [DATA_WIDTH-1:0] modulus,
    input  wire logic [DATA_WIDTH-1:0] exponent,
    output stat_t                      stat,
    output logic      [DATA_WIDTH-1:0] power_result
);

    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] m_reg;
    logic [DATA_WIDTH-1:0] e_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic [DATA_WIDTH-1:0] sq_reg;
    logic [DATA_WIDTH-1:0] p_reg;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH-1:0] out_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH-1:0] p_dbl;
    logic [DATA_WIDTH-1:0] p_step;

    function automatic logic [DATA_WIDTH-1:0] add_mod(
        input logic [DATA_WIDTH-1:0] a,
        input logic [DATA_WIDTH-1:0] b,
        input logic [DATA_WIDTH-1:0] m
    );
        logic [DATA_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // double, then add y when the multiplier msb is set
    assign p_dbl  = add_mod(p_reg, p_reg, m_reg);
    assign p_step = add_mod(p_dbl, x_reg[DATA_WIDTH-1] ? y_reg : '0, m_reg);

    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                m_reg   <= modulus;
                e_reg   <= exponent;
                x_reg   <= base_value;
                y_reg   <= DATA_WIDTH'(1);
                p_reg   <= '0;
                cnt_reg <= '0;
                res_reg <= (modulus == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
            end
            OP_START_ACC: begin
                x_reg   <= res_reg;
                y_reg   <= sq_reg;
                p_reg   <= '0;
                cnt_reg <= '0;
            end
            OP_START_SQ: begin
                x_reg   <= sq_reg;
                y_reg   <= sq_reg;
                p_reg   <= '0;
                cnt_reg <= '0;
            end
            OP_STEP: begin
                p_reg   <= p_step;
                x_reg   <= x_reg << 1;
                cnt_reg <= cnt_reg + CW'(1);
            end
            OP_WB_RES: begin
                res_reg <= p_reg;
            end
            OP_WB_SQ: begin
                sq_reg <= p_reg;
            end
            OP_WB_SQ_SHIFT: begin
                sq_reg <= p_reg;
                e_reg  <= e_reg >> 1;
            end
            OP_FINISH: begin
                out_reg <= (m_reg == '0) ? '0 : res_reg;
            end
            default: ;
        endcase
    end

    assign stat.mul_last = (cnt_reg == CW'(DATA_WIDTH - 1));
    assign stat.exp_bit  = e_reg[0];
    assign stat.exp_done = (e_reg == '0);
    assign power_result  = out_reg;

    `MEXP_ASSERT_NXT(a_step_reduced, aclk, aresetn, (op == OP_STEP) && (m_reg != '0),
        p_reg < m_reg)
    `MEXP_ASSERT_NXT(a_square_reduced, aclk, aresetn,
        (op == OP_WB_SQ_SHIFT) && (m_reg != '0), sq_reg < m_reg)

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus, right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// usage:
//   program modulus (byte address 0) and exponent (byte address 8) over apb
//   while the core is idle; both are cut to DATA_WIDTH bits
//   each item on s_tdata is one base value; one item leaves on m_tdata
//   the base is first reduced, then for each exponent bit up to the
//   highest set one the square is taken, after a multiply when the bit is
//   set, and a finish step ends the item; the passes run on the
//   one-bit-per-cycle shared modular multiplier
//   one item is in work at a time; s_tready is high only when idle
//   the finished item sits in an output register, so a new item is taken
//   while it waits; a stalled receiver holds the core before it finishes
//   reset clears the controller and output valid, modulus to 1, exponent to 0
//   a zero modulus gives 0, a modulus of one gives 0
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FIELD_W-1:0]    s_tdata,    // base_value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [FIELD_W-1:0]    m_tdata,    // power_result
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [DATA_WIDTH-1:0] modulus;
    logic [DATA_WIDTH-1:0] exponent;
    logic [DATA_WIDTH-1:0] power_result;
    stat_t                 stat;
    op_t                   op;

    mexp_cfg #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus),
        .exponent(exponent)
    );

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .op      (op)
    );

    mexp_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .base_value  (s_tdata[DATA_WIDTH-1:0]),
        .modulus     (modulus),
        .exponent    (exponent),
        .stat        (stat),
        .power_result(power_result)
    );

    assign m_tdata = FIELD_W'(power_result);

endmodule

`default_nettype wire

### tb/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// checks base ^ exponent mod modulus against a 128-bit product predictor
// ----------------------------------------------------------------------------
// a short table of directed items covers reset values, modulus one, exponent
// zero, all-ones operands and full-width exponents; random key settings with
// random base values follow. keys are written over apb only while the core
// is drained. both stream sides idle at random, and every result is compared
// in order with the predicted power.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MODULUS  = CFG_ADDR_W'({REG_MODULUS, 3'b000});
    localparam logic [CFG_ADDR_W-1:0] ADDR_EXPONENT = CFG_ADDR_W'({REG_EXPONENT, 3'b000});
    localparam logic [FIELD_W-1:0]    ALL_ONES      = '1;
    localparam logic [FIELD_W-1:0]    PRIME_64      = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int                    RANDOM_ITEMS  = 100;
    localparam int                    DRAIN_CYCLES  = 70;
    localparam longint                CYCLE_LIMIT   = 4_000_000;

    typedef struct packed {
        logic [FIELD_W-1:0] modv;
        logic [FIELD_W-1:0] expv;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] want;
        logic               known;
    } stim_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [FIELD_W-1:0]    s_tdata  = '0;    // base_value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [FIELD_W-1:0]    m_tdata;          // power_result
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [FIELD_W-1:0] key_modulus  = 64'd1;
    logic [FIELD_W-1:0] key_exponent = 64'd0;
    logic [FIELD_W-1:0] expected_powers[$];
    stim_row_t          directed_rows[$];
    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int                 rx_stall  = 0;
    int                 errors    = 0;
    longint             cycles    = 0;

    modular_exponentiation u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] power_mod(input logic [FIELD_W-1:0] b,
                                                     input logic [FIELD_W-1:0] e,
                                                     input logic [FIELD_W-1:0] m);
        logic [2*FIELD_W-1:0] prod;
        logic [FIELD_W-1:0]   acc;
        logic [FIELD_W-1:0]   sq;
        if (m == '0)
            return '0;
        acc = (m == 64'd1) ? '0 : 64'd1;
        sq  = b % m;
        for (int i = 0; i < FIELD_W; i++) begin
            if (e[i]) begin
                prod = {{FIELD_W{1'b0}}, acc} * {{FIELD_W{1'b0}}, sq};
                acc  = FIELD_W'(prod % {{FIELD_W{1'b0}}, m});
            end
            prod = {{FIELD_W{1'b0}}, sq} * {{FIELD_W{1'b0}}, sq};
            sq   = FIELD_W'(prod % {{FIELD_W{1'b0}}, m});
        end
        return acc;
    endfunction

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || rx_steady) begin
            m_tready <= aresetn;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    rx_stall <= $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end
                4: begin
                    rx_stall <= $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_powers.size() == 0)
                report_mismatch("unexpected item", m_tdata, '0);
            else if (m_tdata !== expected_powers[0])
                report_mismatch("power_result", m_tdata, expected_powers[0]);
            if (expected_powers.size() != 0)
                void'(expected_powers.pop_front());
        end
    end

    task automatic send_base(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] want,
                             input logic known);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        expected_powers.push_back(known ? want : power_mod(b, key_exponent, key_modulus));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_MODULUS)
            key_modulus = data;
        else if (addr == ADDR_EXPONENT)
            key_exponent = data;
    endtask

    task automatic load_key(input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] e);
        wait_drained();
        if ($urandom_range(0, 1)) begin
            apb_write(ADDR_MODULUS, m);
            apb_write(ADDR_EXPONENT, e);
        end else begin
            apb_write(ADDR_EXPONENT, e);
            apb_write(ADDR_MODULUS, m);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] e,
                           input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] want,
                           input logic known);
        directed_rows.push_back('{modv: m, expv: e, base: b, want: want, known: known});
    endtask

    initial begin
        logic [FIELD_W-1:0] m;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] b;
        int                 sent;
        int                 run;

        // reset key first, then extremes and special cases
        add_row(64'd1, 64'd0, 64'd0, 64'd0, 1'b1);
        add_row(64'd1, 64'd0, ALL_ONES, 64'd0, 1'b1);
        add_row(ALL_ONES, 64'd0, 64'd5, 64'd1, 1'b1);
        add_row(ALL_ONES, 64'd0, 64'd0, 64'd1, 1'b1);
        add_row(64'd1, ALL_ONES, ALL_ONES, 64'd0, 1'b1);
        add_row(64'd1, ALL_ONES, 64'd12345, 64'd0, 1'b1);
        add_row(ALL_ONES, 64'd1, ALL_ONES, 64'd0, 1'b1);
        add_row(ALL_ONES, 64'd1, ALL_ONES - 1, ALL_ONES - 1, 1'b1);
        add_row(ALL_ONES, 64'd1, 64'd0, 64'd0, 1'b1);
        add_row(ALL_ONES, 64'd2, 64'd2, 64'd4, 1'b1);
        add_row(ALL_ONES, 64'd2, ALL_ONES - 1, 64'd1, 1'b1);
        add_row(PRIME_64, ALL_ONES, 64'd0, 64'd0, 1'b1);
        add_row(PRIME_64, ALL_ONES, 64'd1, 64'd1, 1'b1);
        add_row(PRIME_64, ALL_ONES, 64'h0123_4567_89AB_CDEF, '0, 1'b0);
        add_row(PRIME_64, ALL_ONES, ALL_ONES, '0, 1'b0);
        add_row(64'd7, 64'd3, 64'd10, 64'd6, 1'b1);
        add_row(64'd7, 64'd3, ALL_ONES, '0, 1'b0);
        add_row(64'h8000_0000_0000_0000, 64'd64, 64'd2, 64'd0, 1'b1);
        add_row(64'h8000_0000_0000_0000, 64'd64, 64'd3, '0, 1'b0);
        add_row(64'd1000000007, 64'd1000000005, 64'd2, 64'd500000004, 1'b1);
        add_row(ALL_ONES, ALL_ONES - 1, 64'd3, '0, 1'b0);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'hFFFF_0000_FFFF_0000, '0, 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].modv != key_modulus || directed_rows[i].expv != key_exponent)
                load_key(directed_rows[i].modv, directed_rows[i].expv);
            send_base(directed_rows[i].base, directed_rows[i].want, directed_rows[i].known);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: m = FIELD_W'($urandom_range(1, 255));
                1: m = rand64();
                2: m = ALL_ONES;
                3: m = 64'd1 << $urandom_range(0, 63);
                4: m = {32'd0, $urandom};
                default: m = 64'd1;
            endcase
            if (m == '0)
                m = 64'd1;
            case ($urandom_range(0, 19))
                0: e = '0;
                1: e = ALL_ONES;
                2: e = rand64();
                default: e = rand64() & ((64'd1 << $urandom_range(1, 12)) - 1);
            endcase
            load_key(m, e);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            run = $urandom_range(4, 12);
            for (int k = 0; k < run && sent < RANDOM_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0: b = '0;
                    1: b = ALL_ONES;
                    2: b = m - 1;
                    3: b = m;
                    default: b = rand64();
                endcase
                send_base(b, '0, 1'b0);
                sent++;
            end
        end

        wait_drained();
        rx_steady = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_powers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
